// File: rtl/sorted_cpu_attribute_table_defines.svh
// ----------------------------------------------------------------------------
// sorted_cpu_attribute_table_defines
// assertion macros for the sorted cpu attribute table
// ----------------------------------------------------------------------------
`ifndef SORTED_CPU_ATTRIBUTE_TABLE_DEFINES_SVH
`define SORTED_CPU_ATTRIBUTE_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only while out of reset
`define SCAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define SCAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCAT_ASSERT(lbl, prop, msg)
`define SCAT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/scat_pkg.sv
// ----------------------------------------------------------------------------
// scat_pkg
// shared types and codes of the sorted cpu attribute table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scat_pkg;

  localparam int DEF_ENTRIES = 64;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_SET    = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] grp;
    logic [7:0]  core;
    logic [7:0]  effic;
    logic [7:0]  sched;
    logic        sel;
  } rec_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_t;

endpackage

// File: rtl/scat_rec_mem.sv
// ----------------------------------------------------------------------------
// scat_rec_mem
// record memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scat_rec_mem #(
  parameter int ENTRIES = scat_pkg::DEF_ENTRIES,
  parameter int IW      = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_addr,
  input  scat_pkg::rec_t  wr_data,
  input  logic            rd_en,
  input  logic [IW-1:0]   rd_addr,
  output scat_pkg::rec_t  rd_data
);

  scat_pkg::rec_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/scat_key_cmp.sv
// ----------------------------------------------------------------------------
// scat_key_cmp
// shared key comparator for insertion shifts and binary search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scat_key_cmp (
  input  logic [31:0]    key,
  input  logic [31:0]    stored,
  output scat_pkg::cmp_t cmp
);

  always_comb begin
    cmp.eq = (key == stored);
    cmp.lt = (key < stored);
  end

endmodule

// File: rtl/sorted_cpu_attribute_table.sv
// ----------------------------------------------------------------------------
// sorted_cpu_attribute_table
// table of processor records sorted by id, with insert, lookup and set
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) takes one transaction: func selects
// insert, lookup or set-selection; cpu_id is the key. Output channel
// (out_valid / out_stall) returns exactly one result per input transaction.
// Insert moves one record per cycle through the memory to make room; an
// insert on a full table returns full status without a memory access.
// Lookup and set run a binary search; each halving step is a memory read,
// then a compare, with at most floor(log2(n)) + 1 steps for n stored
// records. in_stall is high while a transaction is being worked on; the
// block takes the next one while a finished result still waits on a stalled
// receiver, and holds a later result until the output frees. Reset (rst,
// synchronous) empties the table at once by clearing the record count;
// memory contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_cpu_attribute_table_defines.svh"

module sorted_cpu_attribute_table #(
  parameter int ENTRIES = scat_pkg::DEF_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] cpu_id,
  input  logic [15:0] group_in,
  input  logic [7:0]  core_in,
  input  logic [7:0]  effic_in,
  input  logic [7:0]  sched_in,
  input  logic        new_selection,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  entry_index,
  output logic [15:0] group_out,
  output logic [23:0] core_id,
  output logic [7:0]  effic_out,
  output logic [7:0]  sched_out,
  output logic        selection_out
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_INS_CMP  = 3'd1;
  localparam logic [2:0] ST_INS_WR   = 3'd2;
  localparam logic [2:0] ST_SRCH_ISS = 3'd3;
  localparam logic [2:0] ST_SRCH_CMP = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  logic [2:0]     state;
  logic [CW-1:0]  entry_count;
  logic [IW-1:0]  pos;
  logic [IW-1:0]  pos_m1;
  logic [CW-1:0]  lo;
  logic [CW-1:0]  hi;
  logic [CW-1:0]  mid;
  logic [CW-1:0]  mid_next;

  logic [1:0]     op;
  scat_pkg::rec_t new_rec;
  logic           sel_wr;

  logic [1:0]     res_status;
  logic [5:0]     res_index;
  scat_pkg::rec_t res_rec;

  logic           wr_en;
  logic [IW-1:0]  wr_addr;
  scat_pkg::rec_t wr_data;
  logic           rd_en;
  logic [IW-1:0]  rd_addr;
  scat_pkg::rec_t rd_data;
  scat_pkg::cmp_t cmp;

  logic           full;
  logic           in_fire;
  logic           out_free;

  assign full     = (entry_count == CW'(ENTRIES));
  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign pos_m1   = pos - 1'b1;
  assign mid_next = lo + ((hi - lo) >> 1);

  scat_rec_mem #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  scat_key_cmp u_cmp (
    .key    (new_rec.key),
    .stored (rd_data.key),
    .cmp    (cmp)
  );

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = pos_m1;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && func == scat_pkg::FUNC_INSERT && !full && entry_count != '0) begin
          rd_en   = 1'b1;
          rd_addr = IW'(entry_count - 1'b1);
        end
      end
      ST_INS_CMP: begin
        // move the larger record up one place, fetch the next one below
        if (cmp.lt) begin
          wr_en = 1'b1;
          if (pos_m1 != '0) begin
            rd_en   = 1'b1;
            rd_addr = pos_m1 - 1'b1;
          end
        end
      end
      ST_INS_WR: begin
        wr_en   = 1'b1;
        wr_data = new_rec;
      end
      ST_SRCH_ISS: begin
        if (lo < hi) begin
          rd_en   = 1'b1;
          rd_addr = mid_next[IW-1:0];
        end
      end
      ST_SRCH_CMP: begin
        if (cmp.eq && op == scat_pkg::FUNC_SET) begin
          wr_en       = 1'b1;
          wr_addr     = mid[IW-1:0];
          wr_data.sel = sel_wr;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      // a result handed over in ST_DONE reloads out_valid below
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            op            <= func;
            new_rec.key   <= cpu_id;
            new_rec.grp   <= group_in;
            new_rec.core  <= core_in;
            new_rec.effic <= effic_in;
            new_rec.sched <= sched_in;
            new_rec.sel   <= 1'b0;
            sel_wr        <= new_selection;
            if (func == scat_pkg::FUNC_INSERT) begin
              if (full) begin
                res_status <= scat_pkg::STATUS_FULL;
                res_index  <= '0;
                res_rec    <= '0;
                state      <= ST_DONE;
              end else begin
                pos   <= IW'(entry_count);
                state <= (entry_count == '0) ? ST_INS_WR : ST_INS_CMP;
              end
            end else begin
              lo    <= '0;
              hi    <= entry_count;
              state <= ST_SRCH_ISS;
            end
          end
        end
        ST_INS_CMP: begin
          if (cmp.lt) begin
            pos <= pos_m1;
            if (pos_m1 == '0) begin
              state <= ST_INS_WR;
            end
          end else begin
            state <= ST_INS_WR;
          end
        end
        ST_INS_WR: begin
          res_status  <= scat_pkg::STATUS_OK;
          res_index   <= 6'(pos);
          res_rec     <= new_rec;
          entry_count <= entry_count + 1'b1;
          state       <= ST_DONE;
        end
        ST_SRCH_ISS: begin
          if (lo < hi) begin
            mid   <= mid_next;
            state <= ST_SRCH_CMP;
          end else begin
            res_status <= scat_pkg::STATUS_NOT_FOUND;
            res_index  <= '0;
            res_rec    <= '0;
            state      <= ST_DONE;
          end
        end
        ST_SRCH_CMP: begin
          if (cmp.eq) begin
            res_status <= scat_pkg::STATUS_OK;
            res_index  <= 6'(mid);
            res_rec    <= rd_data;
            state      <= ST_DONE;
          end else begin
            if (cmp.lt) begin
              hi <= mid;
            end else begin
              lo <= mid + 1'b1;
            end
            state <= ST_SRCH_ISS;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output payload, loaded only when a result is handed over
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      status        <= res_status;
      entry_index   <= res_index;
      group_out     <= res_rec.grp;
      core_id       <= {res_rec.grp, res_rec.core};
      effic_out     <= res_rec.effic;
      sched_out     <= res_rec.sched;
      selection_out <= res_rec.sel;
    end
  end

  `SCAT_ASSERT(a_count_bound, entry_count <= CW'(ENTRIES), "record count beyond table size")
  `SCAT_ASSERT(a_full_status,
               (out_valid && status == scat_pkg::STATUS_FULL) |-> full,
               "full status with free room")
  `SCAT_ASSERT(a_fail_zero,
               (out_valid && status != scat_pkg::STATUS_OK) |->
               (entry_index == '0 && group_out == '0 && selection_out == 1'b0),
               "failed result carries data")
  `SCAT_ASSERT_ALWAYS(a_count_step,
                      (!rst && !$past(rst) && entry_count != $past(entry_count)) |->
                      (entry_count == $past(entry_count) + 1'b1),
                      "record count moved by more than one")

endmodule
